>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/iptrie_pkg.sv
// Shared types and constants of the prefix trie block.
`timescale 1ns / 1ps
`default_nettype none
package iptrie_pkg;
  localparam int NODE_COUNT_DEF = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam logic [31:0] VALUE_EMPTY = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_LOAD, S_INS_END, S_ALLOC, S_POP, S_LINK, S_NEWN,
    S_DEL_END, S_PR_READ, S_PR_LOAD, S_PR_WN, S_PR_WP, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_START, OP_DESCEND, OP_LOAD, OP_INS_SET, OP_ALLOC_FREE,
    OP_ALLOC_POP, OP_ALLOC_UNUSED, OP_LINK, OP_NEWN, OP_DEL_CLEAR,
    OP_PR_READ, OP_PR_LOAD, OP_PR_WN, OP_PR_WP, OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_status;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  reached;
    logic  child_zero;
    logic  at_root;
    logic  cur_child;
    logic  cur_valid;
    logic  free_empty;
    logic  unused_full;
    logic  prune_stop;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> hdl/iptrie_ifs.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface iptrie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] key;
  logic [31:0] prefix_mask;
  logic [31:0] entry_value;
  modport source (output valid, kind, key, prefix_mask, entry_value, input ready);
  modport sink   (input valid, kind, key, prefix_mask, entry_value, output ready);
endinterface

interface iptrie_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [31:0] match_value;
  modport source (output valid, status, found, match_value, input ready);
  modport sink   (input valid, status, found, match_value, output ready);
endinterface
`default_nettype wire

>>> hdl/iptrie_dp.sv
// Trie datapath: node memory, root registers, walk registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module iptrie_dp #(
  parameter int NODE_COUNT = 1024,
  parameter int KEY_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iptrie_pkg::dp_cmd_t  cmd,
  output iptrie_pkg::dp_stat_t stat,
  input  logic [1:0]           in_kind,
  input  logic [31:0]          in_key,
  input  logic [31:0]          in_prefix_mask,
  input  logic [31:0]          in_entry_value,
  output logic [1:0]           out_status,
  output logic                 out_found,
  output logic [31:0]          out_match_value
);
  import iptrie_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int DW = $clog2(KEY_BITS + 1);

  typedef logic [NW-1:0] idx_t;
  typedef struct packed {
    idx_t        left;
    idx_t        right;
    idx_t        up;
    logic [31:0] payload;
    logic        valid;
  } node_t;

  node_t mem [NODE_COUNT];
  node_t mem_q;
  logic  rd_root_r;

  logic  rd_en;
  idx_t  rd_idx;
  logic  wr_en;
  idx_t  wr_idx;
  node_t wr_rec;

  idx_t        root_left_r, root_right_r;
  logic [31:0] root_payload_r;
  logic        root_valid_r;

  kind_t         kind_r;
  logic [KEY_BITS-1:0] key_sh_r, mask_sh_r;
  logic [31:0]   value_r;
  logic [DW-1:0] d_r;
  idx_t          node_r, n_r, free_head_r;
  logic [NW:0]   next_unused_r;
  node_t         cur_r, par_r;
  status_t       status_r;
  logic          found_r;
  logic [31:0]   val_r;

  node_t root_rec, rec, parmod, linked, new_rec, freed, cleared, ins_rec;
  idx_t  child;

  always_comb begin
    root_rec = '{left: root_left_r, right: root_right_r, up: '0,
                 payload: root_payload_r, valid: root_valid_r};
    rec      = rd_root_r ? root_rec : mem_q;
    child    = key_sh_r[KEY_BITS-1] ? cur_r.right : cur_r.left;

    parmod = par_r;
    if (par_r.right == node_r) begin
      parmod.right = '0;
    end else begin
      parmod.left = '0;
    end

    linked = cur_r;
    if (key_sh_r[KEY_BITS-1]) begin
      linked.right = n_r;
    end else begin
      linked.left = n_r;
    end

    new_rec = '{left: '0, right: '0, up: node_r, payload: '0, valid: 1'b0};
    freed   = '{left: '0, right: free_head_r, up: cur_r.up, payload: '0, valid: 1'b0};
    cleared = cur_r;
    cleared.payload = '0;
    cleared.valid   = 1'b0;
    ins_rec = cur_r;
    ins_rec.payload = value_r;
    ins_rec.valid   = 1'b1;
  end

  // Memory port selection per datapath command.
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = '0;
    wr_en  = 1'b0;
    wr_idx = '0;
    wr_rec = cur_r;
    case (cmd.op)
      OP_DESCEND: begin
        rd_en  = 1'b1;
        rd_idx = child;
      end
      OP_ALLOC_FREE: begin
        rd_en  = 1'b1;
        rd_idx = free_head_r;
      end
      OP_PR_READ: begin
        rd_en  = 1'b1;
        rd_idx = cur_r.up;
      end
      OP_INS_SET: begin
        wr_en  = (value_r != VALUE_EMPTY);
        wr_idx = node_r;
        wr_rec = ins_rec;
      end
      OP_LINK: begin
        wr_en  = 1'b1;
        wr_idx = node_r;
        wr_rec = linked;
      end
      OP_NEWN: begin
        wr_en  = 1'b1;
        wr_idx = n_r;
        wr_rec = new_rec;
      end
      OP_DEL_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = node_r;
        wr_rec = cleared;
      end
      OP_PR_WN: begin
        wr_en  = 1'b1;
        wr_idx = node_r;
        wr_rec = freed;
      end
      OP_PR_WP: begin
        wr_en  = 1'b1;
        wr_idx = cur_r.up;
        wr_rec = parmod;
      end
      default: begin
      end
    endcase
  end

  // The root lives in registers so that it reads as empty right after reset.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx != '0)) begin
      mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_idx];
      rd_root_r <= (rd_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_left_r   <= '0;
      root_right_r  <= '0;
      root_valid_r  <= 1'b0;
      free_head_r   <= '0;
      next_unused_r <= (NW+1)'(1);
    end else begin
      if (wr_en && (wr_idx == '0)) begin
        root_left_r    <= wr_rec.left;
        root_right_r   <= wr_rec.right;
        root_valid_r   <= wr_rec.valid;
        root_payload_r <= wr_rec.payload;
      end
      case (cmd.op)
        OP_ALLOC_POP:    free_head_r   <= rec.right;
        OP_ALLOC_UNUSED: next_unused_r <= next_unused_r + (NW+1)'(1);
        OP_PR_WN:        free_head_r   <= node_r;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        kind_r    <= kind_t'(in_kind);
        key_sh_r  <= in_key[KEY_BITS-1:0];
        mask_sh_r <= in_prefix_mask[KEY_BITS-1:0];
        value_r   <= in_entry_value;
        d_r       <= '0;
        node_r    <= '0;
        cur_r     <= root_rec;
        found_r   <= root_valid_r;
        val_r     <= root_valid_r ? root_payload_r : 32'd0;
      end
      OP_DESCEND: begin
        node_r    <= child;
        key_sh_r  <= key_sh_r << 1;
        mask_sh_r <= mask_sh_r << 1;
        d_r       <= d_r + DW'(1);
      end
      OP_LOAD: begin
        cur_r <= rec;
        if (rec.valid) begin
          found_r <= 1'b1;
          val_r   <= rec.payload;
        end
      end
      OP_ALLOC_FREE:   n_r <= free_head_r;
      OP_ALLOC_UNUSED: n_r <= next_unused_r[NW-1:0];
      OP_LINK:         cur_r <= linked;
      OP_NEWN: begin
        cur_r     <= new_rec;
        node_r    <= n_r;
        key_sh_r  <= key_sh_r << 1;
        mask_sh_r <= mask_sh_r << 1;
        d_r       <= d_r + DW'(1);
      end
      OP_PR_LOAD: par_r <= rec;
      OP_PR_WP: begin
        cur_r  <= parmod;
        node_r <= cur_r.up;
      end
      OP_RESULT: begin
        out_status      <= status_r;
        out_found       <= (kind_r == KIND_FIND) && found_r;
        out_match_value <= ((kind_r == KIND_FIND) && found_r) ? val_r : 32'd0;
      end
      default: begin
      end
    endcase
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // A prefix ends at the first zero mask bit; lookups ignore the mask and reach only at full key depth.
  always_comb begin
    stat.kind        = kind_r;
    stat.reached     = (d_r == DW'(KEY_BITS)) ||
                       ((kind_r != KIND_FIND) && !mask_sh_r[KEY_BITS-1]);
    stat.child_zero  = (child == '0);
    stat.at_root     = (node_r == '0);
    stat.cur_child   = (cur_r.left != '0) || (cur_r.right != '0);
    stat.cur_valid   = cur_r.valid;
    stat.free_empty  = (free_head_r == '0);
    stat.unused_full = (next_unused_r == (NW+1)'(NODE_COUNT));
    stat.prune_stop  = (parmod.left != '0) || (parmod.right != '0) ||
                       parmod.valid || (cur_r.up == '0);
  end
endmodule
`default_nettype wire

>>> hdl/iptrie_ctrl.sv
// Trie controller: sequences walk, allocation and pruning steps of the datapath.
`timescale 1ns / 1ps
`default_nettype none
module iptrie_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  iptrie_pkg::dp_stat_t stat,
  output iptrie_pkg::dp_cmd_t  cmd
);
  import iptrie_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (kind_t'(in_kind) == KIND_NONE) ? S_FINISH : S_WALK;
        end
      end
      S_WALK: begin
        if (stat.reached) begin
          unique case (stat.kind)
            KIND_INSERT: state_nxt = S_INS_END;
            KIND_DELETE: state_nxt = S_DEL_END;
            default:     state_nxt = S_FINISH;
          endcase
        end else if (stat.child_zero) begin
          state_nxt = (stat.kind == KIND_INSERT) ? S_ALLOC : S_FINISH;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD:    state_nxt = S_WALK;
      S_INS_END: state_nxt = S_FINISH;
      S_ALLOC: begin
        if (!stat.free_empty) begin
          state_nxt = S_POP;
        end else if (!stat.unused_full) begin
          state_nxt = S_LINK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_POP:  state_nxt = S_LINK;
      S_LINK: state_nxt = S_NEWN;
      S_NEWN: state_nxt = S_WALK;
      S_DEL_END: begin
        state_nxt = (stat.cur_child || stat.at_root) ? S_FINISH : S_PR_READ;
      end
      S_PR_READ: state_nxt = S_PR_LOAD;
      S_PR_LOAD: state_nxt = S_PR_WN;
      S_PR_WN:   state_nxt = S_PR_WP;
      S_PR_WP:   state_nxt = stat.prune_stop ? S_FINISH : S_PR_READ;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NOP, set_status: 1'b0, status: ST_OK};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = '{op: OP_START, set_status: 1'b1, status: ST_OK};
        end
      end
      S_WALK: begin
        if (!stat.reached) begin
          if (!stat.child_zero) begin
            cmd.op = OP_DESCEND;
          end else if (stat.kind == KIND_DELETE) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_ABSENT;
          end
        end
      end
      S_LOAD: cmd.op = OP_LOAD;
      S_INS_END: begin
        cmd.set_status = 1'b1;
        if (stat.cur_valid) begin
          cmd.status = ST_BUSY;
        end else begin
          cmd.op = OP_INS_SET;
        end
      end
      S_ALLOC: begin
        if (!stat.free_empty) begin
          cmd.op = OP_ALLOC_FREE;
        end else if (!stat.unused_full) begin
          cmd.op = OP_ALLOC_UNUSED;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
        end
      end
      S_POP:  cmd.op = OP_ALLOC_POP;
      S_LINK: cmd.op = OP_LINK;
      S_NEWN: cmd.op = OP_NEWN;
      S_DEL_END: begin
        // Inner nodes and the root only lose their value; leaves get pruned.
        if (stat.cur_child || stat.at_root) begin
          cmd.set_status = 1'b1;
          if (stat.cur_valid) begin
            cmd.op = OP_DEL_CLEAR;
          end else begin
            cmd.status = ST_ABSENT;
          end
        end
      end
      S_PR_READ: cmd.op = OP_PR_READ;
      S_PR_LOAD: cmd.op = OP_PR_LOAD;
      S_PR_WN:   cmd.op = OP_PR_WN;
      S_PR_WP:   cmd.op = OP_PR_WP;
      S_FINISH: begin
        if (out_free) begin
          cmd.op = OP_RESULT;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/ipv4_prefix_trie_core.sv
// Top level of the longest-prefix-match binary trie.
// Usage:
//   in_ch carries one request per beat: kind (insert, delete, lookup or
//   none), key, prefix_mask (leading ones give the prefix length) and
//   entry_value. out_ch returns one result beat per request: status,
//   found and match_value.
//   One request is in work at a time; in_ch.ready is high only while the
//   sequencer is idle. Each trie level takes a memory read, then an
//   evaluate step, since the node memory has a single registered read port.
//   Insert takes each new node from the free list (alloc, pop, link and
//   new-node steps) or else from the unused slots (alloc, link and new-node
//   steps). Deleting a leaf prunes it and each parent below the root that
//   is left empty, one node at a time (read, load, free node, write parent).
//   The result sits in an output register; while the receiver stalls, the
//   next request can still be taken and walked, but it waits in the finish
//   state until the held result is taken.
//   Reset empties the trie at once (root in flip-flops, empty free list);
//   no clearing pass is needed, since every node is written on allocation.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_prefix_trie_core #(
  parameter int NODE_COUNT = iptrie_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS   = iptrie_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  iptrie_in_if.sink     in_ch,
  iptrie_out_if.source  out_ch
);
  import iptrie_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iptrie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iptrie_dp #(
    .NODE_COUNT (NODE_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_key          (in_ch.key),
    .in_prefix_mask  (in_ch.prefix_mask),
    .in_entry_value  (in_ch.entry_value),
    .out_status      (out_ch.status),
    .out_found       (out_ch.found),
    .out_match_value (out_ch.match_value)
  );
endmodule
`default_nettype wire

>>> hdl/iptrie_checker.sv
// Port-level assertions of the trie core and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module iptrie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [31:0] out_match_value
);
  import iptrie_pkg::*;

  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found) && $stable(out_match_value), "result beat changed while stalled")
  `ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken while busy")
  `ASSERT_IMP(a_miss_zero, out_valid && !out_found, out_match_value == 32'd0, "miss with nonzero value")
  `ASSERT_IMP(a_hit_ok, out_valid && out_found, out_status == ST_OK, "hit with error status")
  `ASSERT_IMP(a_hit_not_empty, out_valid && out_found, out_match_value != VALUE_EMPTY, "hit returned the empty marker")
endmodule

bind ipv4_prefix_trie_core iptrie_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found       (out_ch.found),
  .out_match_value (out_ch.match_value)
);
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the longest-prefix-match trie core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import iptrie_pkg::*;

  localparam int NODES = 1024;

  typedef struct {
    kind_t       kind;
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] value;
    logic        has_exp;
    status_t     exp_status;
    logic        exp_found;
    logic [31:0] exp_value;
  } stim_row_t;

  typedef struct {
    status_t     status;
    logic        found;
    logic [31:0] value;
  } answer_t;

  logic clk;
  logic rst_n;
  iptrie_in_if  req_if ();
  iptrie_out_if res_if ();

  ipv4_prefix_trie_core DUT (.clk(clk), .rst_n(rst_n), .in_ch(req_if.sink), .out_ch(res_if.source));

  // Shadow trie.
  logic [9:0]  t_left [NODES];
  logic [9:0]  t_right[NODES];
  logic [9:0]  t_up   [NODES];
  logic [31:0] t_val  [NODES];
  logic        t_set  [NODES];
  logic [9:0]  t_free;
  int          t_unused;

  answer_t answers_due[$];
  int errors = 0;
  int beats_out = 0;
  int full_seen = 0;
  bit stall_hold = 0;
  stim_row_t rows[$];
  logic [31:0] known_keys[$];
  logic [31:0] known_masks[$];

  function automatic int mask_len(logic [31:0] m);
    int n;
    n = 0;
    while (n < 32 && m[31 - n]) n++;
    return n;
  endfunction

  function automatic logic [9:0] child(logic [9:0] nd, logic dir);
    return dir ? t_right[nd] : t_left[nd];
  endfunction

  function automatic logic [9:0] take_node();
    logic [9:0] n;
    if (t_free != 0) begin
      n = t_free;
      t_free = t_right[n];
    end else if (t_unused < NODES) begin
      n = t_unused[9:0];
      t_unused++;
    end else begin
      return 0;
    end
    t_left[n] = 0; t_right[n] = 0; t_up[n] = 0; t_val[n] = 0; t_set[n] = 0;
    return n;
  endfunction

  function automatic answer_t trie_apply(kind_t k, logic [31:0] key, logic [31:0] m,
                                         logic [31:0] v);
    answer_t a;
    logic [9:0] nd, c, p;
    int len, d;
    a.status = ST_OK; a.found = 0; a.value = 0;
    len = mask_len(m);
    nd = 0;
    case (k)
      KIND_INSERT: begin
        d = 0;
        while (d < len) begin
          c = child(nd, key[31 - d]);
          if (c == 0) break;
          nd = c; d++;
        end
        if (d == len && t_set[nd]) begin
          a.status = ST_BUSY;
          return a;
        end
        while (d < len) begin
          c = take_node();
          if (c == 0) begin
            a.status = ST_FULL;
            return a;
          end
          t_up[c] = nd;
          if (key[31 - d]) t_right[nd] = c; else t_left[nd] = c;
          nd = c; d++;
        end
        if (v != VALUE_EMPTY) begin
          t_val[nd] = v; t_set[nd] = 1;
        end
      end
      KIND_DELETE: begin
        for (d = 0; d < len; d++) begin
          nd = child(nd, key[31 - d]);
          if (nd == 0) begin
            a.status = ST_ABSENT;
            return a;
          end
        end
        if (t_left[nd] != 0 || t_right[nd] != 0 || nd == 0) begin
          if (!t_set[nd]) a.status = ST_ABSENT;
          else begin
            t_set[nd] = 0; t_val[nd] = 0;
          end
          return a;
        end
        forever begin
          p = t_up[nd];
          if (t_right[p] == nd) t_right[p] = 0; else t_left[p] = 0;
          t_set[nd] = 0; t_val[nd] = 0; t_left[nd] = 0;
          t_right[nd] = t_free; t_free = nd;
          nd = p;
          if (t_left[nd] != 0 || t_right[nd] != 0 || t_set[nd] || nd == 0) break;
        end
      end
      KIND_FIND: begin
        d = 0;
        forever begin
          if (t_set[nd]) begin
            a.found = 1; a.value = t_val[nd];
          end
          if (d >= 32) break;
          nd = child(nd, key[31 - d]);
          if (nd == 0) break;
          d++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls, plus one long hold requested by the sender.
  initial begin
    int g;
    res_if.ready <= 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_hold) begin
        res_if.ready <= 0;
        for (int i = 0; i < 400; i++) @(posedge clk);
        stall_hold = 0;
      end
      g = gap_len();
      res_if.ready <= (g == 0);
      for (int i = 1; i < g; i++) @(posedge clk);
      if (g != 0) begin
        @(posedge clk);
        res_if.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      beats_out++;
      if (res_if.status == ST_FULL) full_seen++;
      if (answers_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: %0d %0d %h", $time,
                 res_if.status, res_if.found, res_if.match_value);
        errors++;
      end else begin
        e = answers_due.pop_front();
        if (res_if.status !== e.status || res_if.found !== e.found ||
            res_if.match_value !== e.value) begin
          $display("%0t: mismatch expected %0d %0d %h actual %0d %0d %h", $time,
                   e.status, e.found, e.value, res_if.status, res_if.found,
                   res_if.match_value);
          errors++;
        end
      end
    end
  end

  task automatic send(stim_row_t r);
    answer_t a;
    req_if.valid <= 1;
    req_if.kind <= r.kind;
    req_if.key <= r.key;
    req_if.prefix_mask <= r.mask;
    req_if.entry_value <= r.value;
    do @(posedge clk); while (!req_if.ready);
    a = trie_apply(r.kind, r.key, r.mask, r.value);
    if (r.has_exp && (a.status !== r.exp_status || a.found !== r.exp_found ||
                      a.value !== r.exp_value)) begin
      $display("%0t: directed row disagrees with predictor: table %0d %0d %h", $time,
               r.exp_status, r.exp_found, r.exp_value);
      errors++;
    end
    answers_due.push_back(a);
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic stim_row_t row(kind_t k, logic [31:0] key, logic [31:0] m,
                                    logic [31:0] v, logic he = 0,
                                    status_t s = ST_OK, logic f = 0,
                                    logic [31:0] ev = 0);
    stim_row_t r;
    r.kind = k; r.key = key; r.mask = m; r.value = v;
    r.has_exp = he; r.exp_status = s; r.exp_found = f; r.exp_value = ev;
    return r;
  endfunction

  function automatic logic [31:0] len_mask(int n);
    return (n == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> n);
  endfunction

  // Half of the rows reuse a key seen before, if any, so deletes and busy inserts can hit.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int pick, len, i;
    r = row(KIND_FIND, $urandom, 0, $urandom);
    if (r.value == VALUE_EMPTY) r.value = 0;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 32) : $urandom_range(0, 12);
    r.mask = len_mask(len);
    if ($urandom_range(0, 3) == 0) r.mask = r.mask | ($urandom & ~len_mask(len + 1)) ;
    if (known_keys.size() > 0 && $urandom_range(0, 1)) begin
      i = $urandom_range(0, known_keys.size() - 1);
      r.key = known_keys[i] ^ ($urandom_range(0, 3) == 0 ? $urandom : 0);
      if ($urandom_range(0, 1)) r.mask = known_masks[i];
    end
    if (pick < 40) r.kind = KIND_INSERT;
    else if (pick < 65) r.kind = KIND_DELETE;
    else if (pick < 97) r.kind = KIND_FIND;
    else r.kind = KIND_NONE;
    if ($urandom_range(0, 30) == 0) r.value = VALUE_EMPTY;
    if (r.kind == KIND_INSERT) begin
      known_keys.push_back(r.key);
      known_masks.push_back(r.mask);
    end
    return r;
  endfunction

  initial begin
    stim_row_t r;
    int drain;
    rst_n <= 0;
    req_if.valid <= 0;
    req_if.kind <= KIND_FIND;
    req_if.key <= 0;
    req_if.prefix_mask <= 0;
    req_if.entry_value <= 0;
    for (int i = 0; i < NODES; i++) begin
      t_left[i] = 0; t_right[i] = 0; t_up[i] = 0; t_val[i] = 0; t_set[i] = 0;
    end
    t_free = 0; t_unused = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    rows.push_back(row(KIND_FIND, 32'h0, 0, 0, 1, ST_OK, 0, 0));
    rows.push_back(row(KIND_DELETE, 32'h0, 0, 0, 1, ST_ABSENT, 0, 0));
    rows.push_back(row(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, ST_ABSENT, 0, 0));
    rows.push_back(row(KIND_INSERT, 32'h0, 0, 32'h5, 1, ST_OK, 0, 0));
    rows.push_back(row(KIND_INSERT, 32'h0, 0, 32'h6, 1, ST_BUSY, 0, 0));
    rows.push_back(row(KIND_FIND, 32'h1234_5678, 0, 0, 1, ST_OK, 1, 32'h5));
    rows.push_back(row(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    rows.push_back(row(KIND_INSERT, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0));
    rows.push_back(row(KIND_INSERT, 32'hC0A8_0100, 32'hFFFF_FF0F, 32'h77));
    rows.push_back(row(KIND_FIND, 32'hC0A8_0105, 0, 0));
    rows.push_back(row(KIND_FIND, 32'hFFFF_FFFF, 0, 0));
    rows.push_back(row(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, VALUE_EMPTY));
    rows.push_back(row(KIND_FIND, 32'h8000_0000, 0, 0));
    rows.push_back(row(KIND_DELETE, 32'hC0A8_0000, 32'hFFFF_0000, 0));
    rows.push_back(row(KIND_DELETE, 32'hC0A8_0000, 32'hFFFF_0000, 0));
    rows.push_back(row(KIND_DELETE, 32'hC0A8_0100, 32'hFFFF_FF00, 0));
    rows.push_back(row(KIND_FIND, 32'hC0A8_0105, 0, 0));
    rows.push_back(row(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0));
    rows.push_back(row(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    rows.push_back(row(KIND_DELETE, 32'h8000_0000, 32'h8000_0000, 0));
    rows.push_back(row(KIND_DELETE, 32'h0, 0, 0, 1, ST_OK, 0, 0));
    rows.push_back(row(KIND_FIND, 32'h0, 0, 0, 1, ST_OK, 0, 0));
    foreach (rows[i]) begin
      send(rows[i]);
      idle_gap();
    end

    // Fill the node store with full-length inserts on random keys so it runs out.
    for (int i = 0; i < 40; i++) begin
      send(row(KIND_INSERT, $urandom, 32'hFFFF_FFFF, $urandom_range(0, 1000)));
      if (i == 5) begin
        stall_hold = 1;
      end
    end
    req_if.valid <= 0;
    // Sender pause until every expected result is in.
    wait (answers_due.size() == 0);
    @(posedge clk);
    for (int i = 0; i < 800; i++) begin
      r = random_row();
      send(r);
      if (i == 400) begin
        req_if.valid <= 0;
        wait (answers_due.size() == 0);
        @(posedge clk);
      end else begin
        idle_gap();
      end
    end
    req_if.valid <= 0;

    drain = 0;
    while (answers_due.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (300) @(posedge clk);
    if (answers_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, answers_due.size());
      errors++;
    end
    $display("Covered %0d result beats over insert, delete, lookup and unused kinds;",
             beats_out);
    $display("store-full answers: %0d, nodes handed out: %0d.", full_seen, t_unused - 1);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/iptrie_pkg.sv
hdl/iptrie_ifs.sv
hdl/iptrie_dp.sv
hdl/iptrie_ctrl.sv
hdl/ipv4_prefix_trie_core.sv
hdl/iptrie_checker.sv
test/testbench.sv
